FILE: rtl/nfbc_pkg.sv
// Shared types and constants of the block cache replacement policy.
`default_nettype none
package nfbc_pkg;

    // Geometry and field widths
    localparam int NFBC_ENTRIES = 16;
    localparam int BLOCK_W      = 20;
    localparam int CMD_W        = 2;
    localparam int KIND_W       = 2;
    localparam int PERIOD_W     = 5;
    localparam int TICK_W       = 4;

    localparam logic [BLOCK_W-1:0]  LOW_BLOCK  = BLOCK_W'(2);
    localparam logic [PERIOD_W-1:0] MAX_PERIOD = PERIOD_W'(16);
    localparam logic [PERIOD_W-1:0] MIN_PERIOD = PERIOD_W'(1);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACCESS = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd3;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EVICT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WBACK = 2'd2;

    // Status codes
    localparam logic STAT_OK        = 1'b0;
    localparam logic STAT_NOT_FOUND = 1'b1;

    // One cache slot as it travels along the row
    typedef struct packed {
        logic [BLOCK_W-1:0] blk;
        logic               valid;
        logic               accessed;
        logic               dirty;
    } t_entry;

    // Operation broadcast to every cell
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_ACCESS,
        OP_SHIFT,
        OP_COMPACT,
        OP_APPEND
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic [BLOCK_W-1:0] key;
        logic               wr;
    } t_cell_ctl;

    // Row status seen by the controller
    typedef struct packed {
        logic   full;
        logic   gap;
        t_entry head;
    } t_row_stat;

endpackage
`default_nettype wire

FILE: rtl/nfbc_cmd_if.sv
// Command channel: valid/ready handshake carrying one command word.
`default_nettype none
interface nfbc_cmd_if
    import nfbc_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [BLOCK_W-1:0] block_number;
    logic               is_write;

    modport source (output valid, output command, output block_number, output is_write,
                    input ready);
    modport sink   (input valid, input command, input block_number, input is_write,
                    output ready);
endinterface
`default_nettype wire

FILE: rtl/nfbc_res_if.sv
// Result channel: valid/ready handshake carrying one result word.
`default_nettype none
interface nfbc_res_if
    import nfbc_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [BLOCK_W-1:0] result_block;
    logic               was_dirty;
    logic               status;
    logic               last;

    modport source (output valid, output kind, output result_block, output was_dirty,
                    output status, output last, input ready);
    modport sink   (input valid, input kind, input result_block, input was_dirty,
                    input status, input last, output ready);
endinterface
`default_nettype wire

FILE: rtl/nru_fifo_block_cache_policy_unit.sv
// Block cache replacement policy: not recently used, falling back to oldest first.
//
// Commands arrive one word at a time on i_cmd (valid/ready) and results leave on o_res;
// every command ends with exactly one done word with last set. Allocation on a full
// cache with a block at or above LOW_BLOCK reports each evicted entry; a sweep tick
// reports each dirty accessed entry. The visit period is written through i_cfg_we /
// i_cfg_data; the user must write it only while the block is idle, which the block
// itself does not enforce. One command is worked on at a time; i_cmd.ready is high only
// when the block is idle. An access, a tick without a sweep and an allocation with room
// or of a low block go straight from taking the command to its done word on o_res. A tick
// sweep takes the command, rotates the slot row through the cells one position a cycle
// while reports can be loaded, through all ENTRIES positions, then checks for a gap and
// gives the done word. A delete does the same, plus a compaction step when the removed
// entry sits ahead of the last used slot. Allocation on a full cache does the same, plus
// one compaction step per freed slot ahead of the last kept entry, or an eviction step
// when the oldest entry must go. A stalled receiver holds the result register; a
// reporting step waits until it drains. Reset (synchronous, active low) empties every
// slot, clears the tick count and sets the visit period to 16. Block numbers of empty slots are not cleared.
`default_nettype none
module nru_fifo_block_cache_policy_unit
    import nfbc_pkg::*;
#(
    parameter int ENTRIES = NFBC_ENTRIES
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    nfbc_cmd_if.sink                 i_cmd,
    nfbc_res_if.source               o_res,
    input  wire logic                i_cfg_we,
    input  wire logic [PERIOD_W-1:0] i_cfg_data
);

    t_cell_ctl ctl;
    t_entry    tail;
    t_row_stat stat;

    // Sequencer
    nfbc_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (i_cmd),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_stat     (stat),
        .o_ctl      (ctl),
        .o_tail     (tail)
    );

    // Slot row
    nfbc_top_row #(
        .ENTRIES (ENTRIES)
    ) u_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_tail  (tail),
        .o_stat  (stat)
    );

endmodule
`default_nettype wire

FILE: rtl/nfbc_cell.sv
// One cache slot of the row: holds an entry and takes its right neighbor's on a shift.
`default_nettype none
module nfbc_cell
    import nfbc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cell_ctl i_ctl,
    input  wire t_entry    i_right,
    input  wire logic      i_hole,
    output t_entry         o_entry,
    output logic           o_hole
);

    logic [BLOCK_W-1:0] r_blk;
    logic               r_valid;
    logic               r_accessed;
    logic               r_dirty;

    logic hit;
    logic take;
    logic fill;

    // Decode the broadcast operation for this slot
    always_comb begin
        hit  = r_valid && (r_blk == i_ctl.key);
        take = (i_ctl.op == OP_SHIFT) ||
               ((i_ctl.op == OP_COMPACT) && (i_hole || !r_valid));
        fill = (i_ctl.op == OP_APPEND) && !r_valid && !i_hole;
    end

    // Block number: payload, no reset
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_blk <= i_right.blk;
        end else if (fill) begin
            r_blk <= i_ctl.key;
        end
    end

    // Valid and marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_accessed <= 1'b0;
            r_dirty    <= 1'b0;
        end else if (take) begin
            r_valid    <= i_right.valid;
            r_accessed <= i_right.accessed;
            r_dirty    <= i_right.dirty;
        end else if (fill) begin
            r_valid    <= 1'b1;
            r_accessed <= 1'b0;
            r_dirty    <= 1'b0;
        end else if ((i_ctl.op == OP_ACCESS) && hit) begin
            r_accessed <= 1'b1;
            r_dirty    <= r_dirty | i_ctl.wr;
        end
    end

    // Pass the entry left and the hole flag right
    assign o_entry = '{blk: r_blk, valid: r_valid, accessed: r_accessed, dirty: r_dirty};
    assign o_hole  = i_hole || !r_valid;

endmodule
`default_nettype wire

FILE: rtl/nfbc_ctrl.sv
// Command sequencer: steps the cell row and drives the registered result word.
`default_nettype none
module nfbc_ctrl
    import nfbc_pkg::*;
#(
    parameter int ENTRIES = NFBC_ENTRIES
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    nfbc_cmd_if.sink                 i_cmd,
    nfbc_res_if.source               o_res,
    input  wire logic                i_cfg_we,
    input  wire logic [PERIOD_W-1:0] i_cfg_data,
    input  wire t_row_stat           i_stat,
    output t_cell_ctl                o_ctl,
    output t_entry                   o_tail
);

    localparam int                STEP_W    = $clog2(ENTRIES);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ENTRIES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROTATE,
        S_COMPACT,
        S_EVICT,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [CMD_W-1:0]    r_cmd;
    logic [BLOCK_W-1:0]  r_key;
    logic                r_wr;
    logic                r_append;
    logic                r_evicted;
    logic                r_found;
    logic [STEP_W-1:0]   r_step;
    logic [TICK_W-1:0]   r_tick;
    logic [PERIOD_W-1:0] r_period;

    logic                r_out_valid;
    logic [KIND_W-1:0]   r_out_kind;
    logic [BLOCK_W-1:0]  r_out_block;
    logic                r_out_dirty;
    logic                r_out_status;
    logic                r_out_last;

    logic                can_load;
    logic                accept;
    logic                head_match;
    logic                head_evict;
    logic                head_wback;
    logic                step_go;
    logic [PERIOD_W-1:0] period_c;
    logic                tick_wrap;

    logic                emit;
    logic [KIND_W-1:0]   emit_kind;
    logic [BLOCK_W-1:0]  emit_block;
    logic                emit_dirty;
    logic                emit_status;
    logic                emit_last;

    assign can_load = !r_out_valid || o_res.ready;
    assign accept   = i_cmd.valid && (r_state == S_IDLE);

    // Clamp the visit period and decide whether this tick sweeps the row
    always_comb begin
        if (r_period < MIN_PERIOD) begin
            period_c = MIN_PERIOD;
        end else if (r_period > MAX_PERIOD) begin
            period_c = MAX_PERIOD;
        end else begin
            period_c = r_period;
        end
        tick_wrap = (PERIOD_W'(r_tick) + PERIOD_W'(1)) >= period_c;
    end

    // Judge the head entry as it wraps to the tail
    always_comb begin
        head_match = i_stat.head.valid && (i_stat.head.blk == r_key);
        head_evict = (r_cmd == CMD_ALLOC) && i_stat.head.valid && !i_stat.head.accessed;
        head_wback = (r_cmd == CMD_TICK) && i_stat.head.valid && i_stat.head.accessed &&
                     i_stat.head.dirty;
    end

    // Drive the row operation, the tail word and the result word
    always_comb begin
        o_ctl       = '{op: OP_HOLD, key: r_key, wr: r_wr};
        o_tail      = '{blk: i_stat.head.blk, valid: 1'b0, accessed: 1'b0, dirty: 1'b0};
        step_go     = 1'b0;
        emit        = 1'b0;
        emit_kind   = KIND_DONE;
        emit_block  = '0;
        emit_dirty  = 1'b0;
        emit_status = STAT_OK;
        emit_last   = 1'b0;
        unique case (r_state)
            S_ROTATE: begin
                step_go = !(head_evict || head_wback) || can_load;
                o_tail  = i_stat.head;
                if (head_evict) begin
                    o_tail.valid    = 1'b0;
                    o_tail.accessed = 1'b0;
                    o_tail.dirty    = 1'b0;
                end else if ((r_cmd == CMD_TICK) && i_stat.head.valid &&
                             i_stat.head.accessed) begin
                    o_tail.accessed = 1'b0;
                    o_tail.dirty    = 1'b0;
                end else if ((r_cmd == CMD_DELETE) && head_match && !r_found) begin
                    o_tail.valid    = 1'b0;
                    o_tail.accessed = 1'b0;
                    o_tail.dirty    = 1'b0;
                end
                if (step_go) begin
                    o_ctl.op = OP_SHIFT;
                end
                emit       = (head_evict || head_wback) && step_go;
                emit_kind  = head_evict ? KIND_EVICT : KIND_WBACK;
                emit_block = i_stat.head.blk;
                emit_dirty = i_stat.head.dirty;
            end
            S_COMPACT: begin
                if (i_stat.gap) begin
                    o_ctl.op = OP_COMPACT;
                end
            end
            S_EVICT: begin
                if (can_load) begin
                    o_ctl.op = OP_SHIFT;
                end
                emit       = can_load;
                emit_kind  = KIND_EVICT;
                emit_block = i_stat.head.blk;
                emit_dirty = i_stat.head.dirty;
            end
            S_DONE: begin
                if (can_load) begin
                    if (r_cmd == CMD_ACCESS) begin
                        o_ctl.op = OP_ACCESS;
                    end else if (r_append) begin
                        o_ctl.op = OP_APPEND;
                    end
                end
                emit        = can_load;
                emit_kind   = KIND_DONE;
                emit_status = ((r_cmd == CMD_DELETE) && !r_found) ? STAT_NOT_FOUND : STAT_OK;
                emit_last   = 1'b1;
            end
            default: begin
                o_ctl.op = OP_HOLD;
            end
        endcase
    end

    // State, counters, configuration and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tick      <= '0;
            r_period    <= MAX_PERIOD;
            r_out_valid <= 1'b0;
            r_append    <= 1'b0;
            r_evicted   <= 1'b0;
            r_found     <= 1'b0;
            r_step      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_period <= i_cfg_data;
            end

            if (emit) begin
                r_out_valid  <= 1'b1;
                r_out_kind   <= emit_kind;
                r_out_block  <= emit_block;
                r_out_dirty  <= emit_dirty;
                r_out_status <= emit_status;
                r_out_last   <= emit_last;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd     <= i_cmd.command;
                        r_key     <= i_cmd.block_number;
                        r_wr      <= i_cmd.is_write;
                        r_append  <= (i_cmd.command == CMD_ALLOC) &&
                                     (i_cmd.block_number >= LOW_BLOCK);
                        r_evicted <= 1'b0;
                        r_found   <= 1'b0;
                        r_step    <= '0;
                        case (i_cmd.command)
                            CMD_ALLOC: begin
                                if ((i_cmd.block_number >= LOW_BLOCK) && i_stat.full) begin
                                    r_state <= S_ROTATE;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            CMD_TICK: begin
                                if (tick_wrap) begin
                                    r_tick  <= '0;
                                    r_state <= S_ROTATE;
                                end else begin
                                    r_tick  <= r_tick + TICK_W'(1);
                                    r_state <= S_DONE;
                                end
                            end
                            CMD_DELETE: begin
                                r_state <= S_ROTATE;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_ROTATE: begin
                    if (step_go) begin
                        if (head_evict) begin
                            r_evicted <= 1'b1;
                        end
                        if ((r_cmd == CMD_DELETE) && head_match) begin
                            r_found <= 1'b1;
                        end
                        r_step <= r_step + STEP_W'(1);
                        if (r_step == LAST_STEP) begin
                            r_state <= S_COMPACT;
                        end
                    end
                end
                S_COMPACT: begin
                    if (!i_stat.gap) begin
                        if ((r_cmd == CMD_ALLOC) && !r_evicted) begin
                            r_state <= S_EVICT;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_EVICT: begin
                    if (can_load) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (can_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Channel outputs
    assign i_cmd.ready        = (r_state == S_IDLE);
    assign o_res.valid        = r_out_valid;
    assign o_res.kind         = r_out_kind;
    assign o_res.result_block = r_out_block;
    assign o_res.was_dirty    = r_out_dirty;
    assign o_res.status       = r_out_status;
    assign o_res.last         = r_out_last;

endmodule
`default_nettype wire

FILE: rtl/nfbc_top_row.sv
// Row of cache slot cells chained left to right, with the row status gathered for control.
`default_nettype none
module nfbc_top_row
    import nfbc_pkg::*;
#(
    parameter int ENTRIES = NFBC_ENTRIES
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cell_ctl i_ctl,
    input  wire t_entry    i_tail,
    output t_row_stat      o_stat
);

    t_entry row   [ENTRIES];
    t_entry right [ENTRIES];
    logic   hole  [ENTRIES+1];
    logic   gap;

    assign hole[0] = 1'b0;

    // Build the chain: each cell sees its right neighbor, the last one the tail word
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        if (g == ENTRIES - 1) begin : g_last
            assign right[g] = i_tail;
        end else begin : g_mid
            assign right[g] = row[g+1];
        end
        nfbc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (i_ctl),
            .i_right (right[g]),
            .i_hole  (hole[g]),
            .o_entry (row[g]),
            .o_hole  (hole[g+1])
        );
    end

    // Flag a free slot followed by a used one
    always_comb begin
        gap = 1'b0;
        for (int i = 0; i < ENTRIES - 1; i++) begin
            gap = gap | (!row[i].valid && row[i+1].valid);
        end
    end

    assign o_stat = '{full: !hole[ENTRIES], gap: gap, head: row[0]};

endmodule
`default_nettype wire
